### src/mbt_pkg.sv
// Shared types, constants and functions of the backpropagation trainer.
// Holds the configuration record, the action and register codes and the
// sigmoid table builder. Depends on nothing.
package mbt_pkg;

  localparam int MAX_LAYERS  = 4;
  localparam int MAX_NEURONS = 16;
  localparam int NIDX_W      = 4;
  localparam int LAYER_W     = 2;
  localparam int NADDR_W     = 1 + LAYER_W + NIDX_W;
  localparam int WPTR_W      = 10;
  localparam int SIG_ENTRIES = 256;
  localparam int SIG_BITS    = 8;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_DATA_W  = 24;

  // Actions carried in tuser of the input stream.
  localparam logic [2:0] ACT_WEIGHT  = 3'd0;
  localparam logic [2:0] ACT_FEATURE = 3'd1;
  localparam logic [2:0] ACT_TARGET  = 3'd2;
  localparam logic [2:0] ACT_START   = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;

  localparam logic [1:0] RUN_LEARN    = 2'd0;
  localparam logic [1:0] RUN_TEST     = 2'd1;
  localparam logic [1:0] RUN_CLASSIFY = 2'd2;

  localparam logic [2:0] REG_LAYER_COUNT   = 3'd0;
  localparam logic [2:0] REG_INPUT_SIZE    = 3'd1;
  localparam logic [2:0] REG_HIDDEN_ONE    = 3'd2;
  localparam logic [2:0] REG_HIDDEN_TWO    = 3'd3;
  localparam logic [2:0] REG_LAST_LAYER    = 3'd4;
  localparam logic [2:0] REG_LEARNING_RATE = 3'd5;
  localparam logic [2:0] REG_CLASSIFY_MODE = 3'd6;

  typedef struct packed {
    logic [2:0]  layer_count;
    logic [4:0]  input_size;
    logic [4:0]  hidden_one_size;
    logic [4:0]  hidden_two_size;
    logic [4:0]  last_layer_size;
    logic [23:0] learning_rate;
    logic        classify_mode;
  } cfg_t;

  typedef logic [SIG_ENTRIES-1:0][15:0] sig_tab_t;

  // Division truncated toward zero by shift and subtract; only the table
  // builder below calls it, at elaboration.
  function automatic longint tdiv(input longint a, input longint b);
    logic [63:0] ua, ub, qt, rm;
    logic        neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    qt = '0;
    rm = '0;
    for (int i = 63; i >= 0; i--) begin
      rm = {rm[62:0], ua[i]};
      if (rm >= ub) begin
        rm = rm - ub;
        qt[i] = 1'b1;
      end
    end
    return neg ? -longint'(qt) : longint'(qt);
  endfunction

  // Sigmoid at the center of each segment of [-8, 8), from a truncated
  // exponential series in Q2.30 followed by four squarings.
  function automatic sig_tab_t build_sig_tab();
    sig_tab_t tab;
    longint one, m, t, u, term, e, s;
    one = longint'(1) <<< 30;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      m = -longint'(524288) +
          tdiv(longint'(2 * i + 1) * longint'(1048576), longint'(2 * SIG_ENTRIES));
      t = (m < 0) ? -m : m;
      u = t * 1024;
      term = one;
      e = one;
      for (int n = 1; n <= 12; n++) begin
        term = tdiv(tdiv(-(term * u), one), longint'(n));
        e = e + term;
      end
      for (int k = 0; k < 4; k++) e = tdiv(e * e, one);
      if (m >= 0) s = tdiv(longint'(65536) * one, one + e);
      else s = tdiv(longint'(65536) * e, one + e);
      if (s > 65535) s = 65535;
      if (s < 0) s = 0;
      tab[i] = 16'(s);
    end
    return tab;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [55:0] v);
    logic signed [23:0] r;
    if (v > 56'sd8388607) r = 24'sd8388607;
    else if (v < -56'sd8388608) r = -24'sd8388608;
    else r = v[23:0];
    return r;
  endfunction

  // Layer size minus one, with zero taken as one and large values capped.
  function automatic logic [NIDX_W-1:0] size_m1(input logic [4:0] v);
    logic [NIDX_W-1:0] r;
    if (v == 5'd0) r = '0;
    else if (v > 5'(MAX_NEURONS)) r = NIDX_W'(MAX_NEURONS - 1);
    else r = NIDX_W'(v - 5'd1);
    return r;
  endfunction

  function automatic logic [31:0] err_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

### src/mbt_ram.sv
// Single-clock RAM with one write port and one registered read port.
// Used for the weight store and the neuron store. No package needed.
module mbt_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### src/mbt_core.sv
// Run sequencer and datapath: forward pass, deltas, weight update, error
// and classification. Uses mbt_pkg and drives two mbt_ram instances.
module mbt_core #(
  parameter int WEIGHT_DEPTH = 1024,
  localparam int WAW = $clog2(WEIGHT_DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mbt_pkg::cfg_t                     cfg,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mbt_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic [2:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mbt_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tlast,
  output logic                              w_we,
  output logic [WAW-1:0]                    w_waddr,
  output logic [23:0]                       w_wdata,
  output logic [WAW-1:0]                    w_raddr,
  input  logic [23:0]                       w_rdata,
  output logic                              n_we,
  output logic [mbt_pkg::NADDR_W-1:0]       n_waddr,
  output logic [23:0]                       n_wdata,
  output logic [mbt_pkg::NADDR_W-1:0]       n_raddr,
  input  logic [23:0]                       n_rdata
);
  import mbt_pkg::*;

  localparam sig_tab_t SIG_TAB = build_sig_tab();

  typedef enum logic [4:0] {
    S_IDLE, S_SETUP,
    S_F_RD, S_F_MUL, S_F_ACC, S_F_SIG,
    S_OD_RD, S_OD_SLP, S_OD_MUL, S_OD_WR,
    S_H_RD, S_H_MUL, S_H_ACC, S_H_ARD, S_H_SLP, S_H_M1, S_H_M2, S_H_WR,
    S_U_DRD, S_U_DLD, S_U_RD, S_U_RA, S_U_MUL, S_U_WR,
    S_SE_RD, S_SE_DIF, S_SE_SQ, S_SE_ADD,
    S_M_CHK, S_O_RD, S_O_LD
  } state_t;

  state_t state;

  logic [NIDX_W-1:0]  szm1 [MAX_LAYERS];
  logic [LAYER_W-1:0] o, l;
  logic [1:0]         mode;
  logic [NIDX_W-1:0]  n, p, f, cand;
  logic [WPTR_W-1:0]  wptr, off2, off3;
  logic               have_best;
  logic [15:0]        best;
  logic [31:0]        err;
  logic [15:0]        tgt [MAX_NEURONS];

  logic signed [55:0] acc;
  logic signed [47:0] prod;
  logic [14:0]        slope;
  logic signed [16:0] diff;
  logic signed [32:0] dprod;
  logic [30:0]        plo;
  logic signed [39:0] phi;
  logic signed [23:0] dreg, wold;
  logic [23:0]        ra;
  logic signed [48:0] up;
  logic [17:0]        sq;

  // Input item fields.
  logic [2:0]          action;
  logic [9:0]          slot;
  logic signed [23:0]  sval;
  logic [1:0]          rmode;
  logic                s_acc;
  logic [15:0]         q;

  logic [LAYER_W-1:0]  lm1, lp1;
  logic [15:0]         act_rd, tgt_rd, sig_val;
  logic [NIDX_W-1:0]   tgt_idx;
  logic signed [23:0]  wval;
  logic                w_in_range;
  logic [32:0]         sprod;
  logic [14:0]         slope_next;
  logic signed [39:0]  zs;
  logic [SIG_BITS-1:0] sidx;
  logic [39:0]         rprod;
  logic signed [33:0]  sqp;
  logic signed [55:0]  od_val, h_val, u_val;
  logic [LAYER_W-1:0]  o_init;
  logic [4:0]          sz0, sz1, sz2;

  function automatic logic [4:0] szk(input logic [NIDX_W-1:0] m1);
    return {1'b0, m1} + 5'd1;
  endfunction

  function automatic logic [WPTR_W-1:0] off_sel(input logic [LAYER_W-1:0] ly,
                                                input logic [WPTR_W-1:0] o2,
                                                input logic [WPTR_W-1:0] o3);
    logic [WPTR_W-1:0] r;
    case (ly)
      2'd2:    r = o2;
      2'd3:    r = o3;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign action = s_tuser;
  assign slot   = s_tdata[9:0];
  assign sval   = $signed(s_tdata[33:10]);
  assign rmode  = s_tdata[35:34];
  assign s_tready = (state == S_IDLE);
  assign s_acc  = s_tvalid && s_tready;

  always_comb begin
    if (sval < 24'sd0) q = 16'd0;
    else if (sval > 24'sd65535) q = 16'hFFFF;
    else q = sval[15:0];
  end

  assign lm1 = l - 2'd1;
  assign lp1 = l + 2'd1;
  assign act_rd = n_rdata[15:0];
  assign tgt_idx = (state == S_M_CHK) ? cand : n;
  assign tgt_rd = tgt[tgt_idx];
  assign w_in_range = int'(wptr) < WEIGHT_DEPTH;
  assign wval = w_in_range ? $signed(w_rdata) : 24'sd0;

  assign sprod = 33'(act_rd) * (33'd65536 - 33'(act_rd));
  assign slope_next = sprod[30:16];

  assign zs = acc[55:16];
  always_comb begin
    if (zs < -40'sd524288) sidx = '0;
    else if (zs > 40'sd524287) sidx = '1;
    else sidx = {~zs[19], zs[18:20-SIG_BITS]};
  end
  assign sig_val = SIG_TAB[sidx];

  assign rprod = 40'(cfg.learning_rate) * 40'(act_rd);
  assign sqp = diff * diff;
  assign od_val = 56'(dprod >>> 16);
  assign h_val = 56'(phi) + $signed({41'd0, plo[30:16]});
  assign u_val = 56'(wold) + 56'(up >>> 16);

  assign o_init = (cfg.layer_count <= 3'd2) ? 2'd1 :
                  ((cfg.layer_count == 3'd3) ? 2'd2 : 2'd3);
  assign sz0 = szk(szm1[0]);
  assign sz1 = szk(szm1[1]);
  assign sz2 = szk(szm1[2]);

  // Read addresses stay put across the read state and the one after it.
  always_comb begin
    case (state)
      S_F_RD, S_F_MUL:                         n_raddr = {1'b0, lm1, p};
      S_H_RD, S_H_MUL:                         n_raddr = {1'b1, lp1, f};
      S_H_ARD, S_H_SLP:                        n_raddr = {1'b0, l, n};
      S_U_DRD, S_U_DLD:                        n_raddr = {1'b1, l, n};
      S_U_RD, S_U_RA:                          n_raddr = {1'b0, lm1, p};
      S_OD_RD, S_OD_SLP, S_SE_RD, S_SE_DIF,
      S_O_RD, S_O_LD:                          n_raddr = {1'b0, o, n};
      default:                                 n_raddr = '0;
    endcase
  end
  assign w_raddr = WAW'(wptr);

  always_comb begin
    n_we = 1'b0;
    n_waddr = '0;
    n_wdata = '0;
    w_we = 1'b0;
    w_waddr = '0;
    w_wdata = '0;
    case (state)
      S_IDLE: begin
        if (s_acc && action == ACT_FEATURE && slot < 10'(MAX_NEURONS)) begin
          n_we = 1'b1;
          n_waddr = {1'b0, 2'd0, slot[NIDX_W-1:0]};
          n_wdata = {8'd0, q};
        end
        if (s_acc && action == ACT_WEIGHT && int'(slot) < WEIGHT_DEPTH) begin
          w_we = 1'b1;
          w_waddr = WAW'(slot);
          w_wdata = sval;
        end
      end
      S_F_SIG: begin
        n_we = 1'b1;
        n_waddr = {1'b0, l, n};
        n_wdata = {8'd0, sig_val};
      end
      S_OD_WR: begin
        n_we = 1'b1;
        n_waddr = {1'b1, o, n};
        n_wdata = sat24(od_val);
      end
      S_H_WR: begin
        n_we = 1'b1;
        n_waddr = {1'b1, l, n};
        n_wdata = sat24(h_val);
      end
      S_U_WR: begin
        w_we = w_in_range;
        w_waddr = WAW'(wptr);
        w_wdata = sat24(u_val);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      err <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_O_LD) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            case (action)
              ACT_TARGET: if (slot < 10'(MAX_NEURONS)) tgt[slot[NIDX_W-1:0]] <= q;
              ACT_CLEAR:  err <= '0;
              ACT_START: begin
                if (rmode <= RUN_CLASSIFY) begin
                  mode <= rmode;
                  szm1[0] <= size_m1(cfg.input_size);
                  szm1[1] <= size_m1(cfg.hidden_one_size);
                  szm1[2] <= size_m1(cfg.hidden_two_size);
                  szm1[3] <= size_m1(cfg.last_layer_size);
                  o <= o_init;
                  state <= S_SETUP;
                end
              end
              default: ;
            endcase
          end
        end
        S_SETUP: begin
          off2 <= WPTR_W'(10'(sz0) * 10'(sz1));
          off3 <= WPTR_W'(10'(sz0) * 10'(sz1) + 10'(sz1) * 10'(sz2));
          l <= 2'd1;
          n <= '0;
          p <= '0;
          acc <= '0;
          wptr <= '0;
          have_best <= 1'b0;
          best <= '0;
          cand <= '0;
          state <= S_F_RD;
        end
        S_F_RD: state <= S_F_MUL;
        S_F_MUL: begin
          prod <= 48'($signed({1'b0, act_rd}) * wval);
          state <= S_F_ACC;
        end
        S_F_ACC: begin
          acc <= acc + 56'(prod);
          wptr <= wptr + 1'b1;
          if (p == szm1[lm1]) state <= S_F_SIG;
          else begin
            p <= p + 1'b1;
            state <= S_F_RD;
          end
        end
        S_F_SIG: begin
          if (l == o && sig_val >= 16'd32768 && (!have_best || sig_val > best)) begin
            have_best <= 1'b1;
            best <= sig_val;
            cand <= n;
          end
          acc <= '0;
          p <= '0;
          if (n == szm1[l]) begin
            n <= '0;
            if (l == o) begin
              case (mode)
                RUN_LEARN: state <= S_OD_RD;
                RUN_TEST:  state <= cfg.classify_mode ? S_M_CHK : S_SE_RD;
                default:   state <= S_O_RD;
              endcase
            end else begin
              l <= l + 2'd1;
              state <= S_F_RD;
            end
          end else begin
            n <= n + 1'b1;
            state <= S_F_RD;
          end
        end
        S_OD_RD: state <= S_OD_SLP;
        S_OD_SLP: begin
          slope <= slope_next;
          diff <= $signed({1'b0, tgt_rd}) - $signed({1'b0, act_rd});
          state <= S_OD_MUL;
        end
        S_OD_MUL: begin
          dprod <= diff * $signed({1'b0, slope});
          state <= S_OD_WR;
        end
        S_OD_WR: begin
          if (n == szm1[o]) begin
            n <= '0;
            if (o != 2'd1) begin
              l <= o - 2'd1;
              f <= '0;
              acc <= '0;
              wptr <= off_sel(o, off2, off3);
              state <= S_H_RD;
            end else begin
              l <= 2'd1;
              p <= '0;
              wptr <= '0;
              state <= S_U_DRD;
            end
          end else begin
            n <= n + 1'b1;
            state <= S_OD_RD;
          end
        end
        S_H_RD: state <= S_H_MUL;
        S_H_MUL: begin
          prod <= $signed(n_rdata) * wval;
          state <= S_H_ACC;
        end
        S_H_ACC: begin
          acc <= acc + 56'(prod);
          wptr <= wptr + WPTR_W'(szk(szm1[l]));
          if (f == szm1[lp1]) state <= S_H_ARD;
          else begin
            f <= f + 1'b1;
            state <= S_H_RD;
          end
        end
        S_H_ARD: state <= S_H_SLP;
        S_H_SLP: begin
          slope <= slope_next;
          state <= S_H_M1;
        end
        // The shifted sum is split at bit 16 so that each product stays narrow.
        S_H_M1: begin
          plo <= 31'(acc[31:16]) * 31'(slope);
          state <= S_H_M2;
        end
        S_H_M2: begin
          phi <= $signed(acc[55:32]) * $signed({1'b0, slope});
          state <= S_H_WR;
        end
        S_H_WR: begin
          acc <= '0;
          f <= '0;
          if (n == szm1[l]) begin
            n <= '0;
            if (l == 2'd1) begin
              p <= '0;
              wptr <= '0;
              state <= S_U_DRD;
            end else begin
              l <= l - 2'd1;
              wptr <= off_sel(l, off2, off3);
              state <= S_H_RD;
            end
          end else begin
            n <= n + 1'b1;
            wptr <= off_sel(lp1, off2, off3) + WPTR_W'(n) + 1'b1;
            state <= S_H_RD;
          end
        end
        S_U_DRD: state <= S_U_DLD;
        S_U_DLD: begin
          dreg <= $signed(n_rdata);
          state <= S_U_RD;
        end
        S_U_RD: state <= S_U_RA;
        S_U_RA: begin
          ra <= rprod[39:16];
          wold <= wval;
          state <= S_U_MUL;
        end
        S_U_MUL: begin
          up <= $signed({1'b0, ra}) * dreg;
          state <= S_U_WR;
        end
        S_U_WR: begin
          wptr <= wptr + 1'b1;
          if (p == szm1[lm1]) begin
            p <= '0;
            if (n == szm1[l]) begin
              n <= '0;
              if (l == o) state <= S_O_RD;
              else begin
                l <= l + 2'd1;
                state <= S_U_DRD;
              end
            end else begin
              n <= n + 1'b1;
              state <= S_U_DRD;
            end
          end else begin
            p <= p + 1'b1;
            state <= S_U_RD;
          end
        end
        S_SE_RD: state <= S_SE_DIF;
        S_SE_DIF: begin
          diff <= $signed({1'b0, tgt_rd}) - $signed({1'b0, act_rd});
          state <= S_SE_SQ;
        end
        S_SE_SQ: begin
          sq <= sqp[33:16];
          state <= S_SE_ADD;
        end
        S_SE_ADD: begin
          err <= err_add(err, 32'(sq));
          if (n == szm1[o]) begin
            n <= '0;
            state <= S_O_RD;
          end else begin
            n <= n + 1'b1;
            state <= S_SE_RD;
          end
        end
        S_M_CHK: begin
          if (!have_best || tgt_rd != 16'hFFFF) err <= err_add(err, 32'd65536);
          state <= S_O_RD;
        end
        S_O_RD: state <= S_O_LD;
        S_O_LD: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {3'd0, err, (n == cand), act_rd, n};
            m_tlast <= (n == szm1[o]);
            if (n == szm1[o]) state <= S_IDLE;
            else begin
              n <= n + 1'b1;
              state <= S_O_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_err_mono: assert property (@(posedge clk) disable iff (rst)
    !(s_acc && action == ACT_CLEAR) |=> err >= $past(err))
    else $error("error total decreased without a clear");

  a_wmem_write: assert property (@(posedge clk) disable iff (rst)
    w_we |-> (state == S_IDLE || state == S_U_WR))
    else $error("weight store written outside a load or an update step");

  a_out_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_O_LD) |-> (n <= szm1[o]))
    else $error("result index beyond the output layer");

endmodule

### src/mlp_backprop_trainer_unit.sv
// Fixed-point sigmoid MLP trainer. A run does the forward pass; learn adds output
// deltas, hidden deltas and the weight update; test adds the squared error per output
// neuron, or a miss count in classify mode; then one result per output neuron follows.
// All steps share the weight store's single read and write ports and one multiply per cycle.
// Reset (synchronous): control, error total and registers to defaults; stores keep data.
module mlp_backprop_trainer_unit #(
  parameter int WEIGHT_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // slot[9:0], sample_value[33:10], run_mode[35:34], zero pad
  input  logic [2:0]  s_tuser,   // action[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // neuron_index[3:0], neuron_output[19:4], class_bit[20],
                                 // error_sum[52:21], zero pad
  output logic        m_tlast,   // last_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import mbt_pkg::*;

  localparam int WAW = $clog2(WEIGHT_DEPTH);

  cfg_t cfg;

  logic               w_we, n_we;
  logic [WAW-1:0]     w_waddr, w_raddr;
  logic [23:0]        w_wdata, w_rdata, n_wdata, n_rdata;
  logic [NADDR_W-1:0] n_waddr, n_raddr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layer_count <= 3'd3;
      cfg.input_size <= 5'd16;
      cfg.hidden_one_size <= 5'd16;
      cfg.hidden_two_size <= 5'd16;
      cfg.last_layer_size <= 5'd4;
      cfg.learning_rate <= 24'd6554;
      cfg.classify_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LAYER_COUNT:   cfg.layer_count <= cfg_data[2:0];
        REG_INPUT_SIZE:    cfg.input_size <= cfg_data[4:0];
        REG_HIDDEN_ONE:    cfg.hidden_one_size <= cfg_data[4:0];
        REG_HIDDEN_TWO:    cfg.hidden_two_size <= cfg_data[4:0];
        REG_LAST_LAYER:    cfg.last_layer_size <= cfg_data[4:0];
        REG_LEARNING_RATE: cfg.learning_rate <= cfg_data;
        REG_CLASSIFY_MODE: cfg.classify_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mbt_ram #(.DEPTH(WEIGHT_DEPTH), .WIDTH(24)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // Activations in the lower half, deltas in the upper half, 16 per layer.
  mbt_ram #(.DEPTH(2 ** NADDR_W), .WIDTH(24)) u_neuron_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  mbt_core #(.WEIGHT_DEPTH(WEIGHT_DEPTH)) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .w_we     (w_we),
    .w_waddr  (w_waddr),
    .w_wdata  (w_wdata),
    .w_raddr  (w_raddr),
    .w_rdata  (w_rdata),
    .n_we     (n_we),
    .n_waddr  (n_waddr),
    .n_wdata  (n_wdata),
    .n_raddr  (n_raddr),
    .n_rdata  (n_rdata)
  );

endmodule
